/* hdl/dbmr_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and codes of the disc blob mask rasterizer
package dbmr_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int WORD_BITS = 32;
  localparam int DEPTH     = (MAX_COLS * MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = $clog2(DEPTH);
  localparam int BW        = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BLOB  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_COLS     = 3'd0,
    REG_ROWS     = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_PIXEL_W  = 3'd4,
    REG_PIXEL_H  = 3'd5,
    REG_MARGIN   = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    F_IDLE, F_DSET, F_DIV, F_RNG, F_M1, F_M2, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLR, B_IDLE, B_RD, B_RD2, B_ROW, B_SQ, B_WR, B_DONE
  } back_state_e;

  // one classified command as it travels from front to back
  typedef struct packed {
    op_e                op;
    logic [10:0]        word_index;
    logic [8:0]         c0;
    logic [8:0]         c1;
    logic [8:0]         r0;
    logic [8:0]         r1;
    logic signed [35:0] dx0;
    logic signed [35:0] dy0;
    logic [24:0]        t;
    logic [49:0]        t2;
    logic [17:0]        base0;
  } cmd_t;

endpackage

/* hdl/dbmr_fifo.sv */
`timescale 1ns / 1ps
// two-entry command queue between front and back
module dbmr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbmr_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output dbmr_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  import dbmr_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

/* hdl/dbmr_front.sv */
`timescale 1ns / 1ps
// front end: accepts items, finds blob centre, box and threshold
module dbmr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               hold_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] blob_x_i,
  input  logic signed [31:0] blob_y_i,
  input  logic [23:0]        blob_r_i,
  input  logic [10:0]        word_index_i,
  input  logic [8:0]         cols_i,
  input  logic [8:0]         rows_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic [15:0]        pixel_w_i,
  input  logic [15:0]        pixel_h_i,
  input  logic [9:0]         margin_i,
  output logic               push_o,
  output dbmr_pkg::cmd_t     cmd_o,
  input  logic               full_i
);
  import dbmr_pkg::*;

  // one end of an axis range, clamped to [0, lim]
  function automatic logic [8:0] axis_end(logic signed [34:0] c, logic [24:0] h,
                                          logic [9:0] mg, logic [8:0] lim,
                                          logic upper);
    logic signed [43:0] half, e, ce, me;
    logic [43:0]        sh;
    half = $signed({19'd0, h}) + 44'sd1;
    ce   = $signed({{9{c[34]}}, c});
    me   = $signed({34'd0, mg});
    if (upper) e = ((ce + half) <<< 4) + me;
    else e = ((ce - half) <<< 4) - me;
    sh = 44'(e >>> 4);
    if (e <= 44'sd0) axis_end = 9'd0;
    else if (sh > {35'd0, lim}) axis_end = lim;
    else axis_end = sh[8:0];
  endfunction

  front_state_e       state_q, state_d;
  logic [1:0]         sel_q;
  logic [5:0]         cnt_q;
  op_e                op_q;
  logic signed [31:0] bx_q, by_q;
  logic [23:0]        r_q;
  logic [10:0]        widx_q;
  logic [33:0]        quo_q;
  logic [17:0]        rem_q, den_q;
  logic               neg_q;
  logic signed [34:0] ci_q, cj_q;
  logic [24:0]        hw_q, hh_q;
  logic [8:0]         c0_q, c1_q, r0_q, r1_q;
  logic [26:0]        tm_q;
  logic [24:0]        t_q, c0pw_q, r0ph_q;
  logic [17:0]        base_q;
  logic [49:0]        t2_q;
  logic signed [35:0] dx0_q, dy0_q;

  logic signed [32:0] sd;
  logic [32:0]        mag;
  logic [33:0]        n_set;
  logic [17:0]        d_set;
  logic [18:0]        rem_ext, rem_nx;
  logic               ge;
  logic [33:0]        quo_nx;
  logic signed [34:0] qs;
  logic               accept;

  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  // divider operands: rounded centre on x and y, then box half size on x and y
  always_comb begin
    sd = '0;
    n_set = '0;
    d_set = '0;
    case (sel_q)
      2'd0: begin
        sd    = {bx_q[31], bx_q} - {origin_x_i[31], origin_x_i};
        d_set = {1'b0, pixel_w_i, 1'b0};
      end
      2'd1: begin
        sd    = {origin_y_i[31], origin_y_i} - {by_q[31], by_q};
        d_set = {1'b0, pixel_h_i, 1'b0};
      end
      2'd2: begin
        n_set = {10'd0, r_q} + {18'd0, pixel_w_i} - 34'd1;
        d_set = {2'd0, pixel_w_i};
      end
      default: begin
        n_set = {10'd0, r_q} + {18'd0, pixel_h_i} - 34'd1;
        d_set = {2'd0, pixel_h_i};
      end
    endcase
    mag = sd[32] ? 33'(-sd) : 33'(sd);
    // 2*|n| + pixel over 2*pixel rounds half away from zero
    if (!sel_q[1]) n_set = {mag, 1'b0} + {17'd0, d_set[17:1]};
  end

  assign rem_ext = {rem_q, quo_q[33]};
  assign ge      = rem_ext >= {1'b0, den_q};
  assign rem_nx  = ge ? rem_ext - {1'b0, den_q} : rem_ext;
  assign quo_nx  = {quo_q[32:0], ge};
  assign qs      = $signed({1'b0, quo_nx});

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = (op_e'(op_i) == OP_BLOB) ? F_DSET : F_PUSH;
      F_DSET: state_d = F_DIV;
      F_DIV:  if (cnt_q == 6'd33) state_d = (sel_q == 2'd3) ? F_RNG : F_DSET;
      F_RNG:  state_d = F_M1;
      F_M1:   state_d = F_M2;
      F_M2:   state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      sel_q   <= 2'd0;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      if (accept) sel_q <= 2'd0;
      else if (state_q == F_DIV && cnt_q == 6'd33) sel_q <= sel_q + 2'd1;
      if (state_q == F_DSET) cnt_q <= 6'd0;
      else if (state_q == F_DIV) cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      bx_q   <= blob_x_i;
      by_q   <= blob_y_i;
      r_q    <= blob_r_i;
      widx_q <= word_index_i;
    end
    case (state_q)
      F_DSET: begin
        quo_q <= n_set;
        den_q <= d_set;
        rem_q <= '0;
        neg_q <= sd[32] && !sel_q[1];
      end
      F_DIV: begin
        quo_q <= quo_nx;
        rem_q <= rem_nx[17:0];
        if (cnt_q == 6'd33) begin
          case (sel_q)
            2'd0:    ci_q <= neg_q ? -qs : qs;
            2'd1:    cj_q <= neg_q ? -qs : qs;
            2'd2:    hw_q <= quo_nx[24:0];
            default: hh_q <= quo_nx[24:0];
          endcase
        end
      end
      F_RNG: begin
        c0_q <= axis_end(ci_q, hw_q, margin_i, cols_i, 1'b0);
        c1_q <= axis_end(ci_q, hw_q, margin_i, cols_i, 1'b1);
        r0_q <= axis_end(cj_q, hh_q, margin_i, rows_i, 1'b0);
        r1_q <= axis_end(cj_q, hh_q, margin_i, rows_i, 1'b1);
        tm_q <= 27'(margin_i) * ({11'd0, pixel_w_i} + {11'd0, pixel_h_i});
      end
      F_M1: begin
        t_q    <= {1'b0, r_q} + {3'd0, tm_q[26:5]};
        c0pw_q <= 25'(c0_q) * 25'(pixel_w_i);
        r0ph_q <= 25'(r0_q) * 25'(pixel_h_i);
        base_q <= 18'(r0_q) * 18'(cols_i);
      end
      F_M2: begin
        t2_q  <= 50'(t_q) * 50'(t_q);
        dx0_q <= $signed({{4{origin_x_i[31]}}, origin_x_i}) + $signed({11'd0, c0pw_q})
                 - $signed({{4{bx_q[31]}}, bx_q});
        dy0_q <= $signed({{4{origin_y_i[31]}}, origin_y_i}) - $signed({11'd0, r0ph_q})
                 - $signed({{4{by_q[31]}}, by_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.op         = op_q;
    cmd_o.word_index = widx_q;
    cmd_o.c0         = c0_q;
    cmd_o.c1         = c1_q;
    cmd_o.r0         = r0_q;
    cmd_o.r1         = r1_q;
    cmd_o.dx0        = dx0_q;
    cmd_o.dy0        = dy0_q;
    cmd_o.t          = t_q;
    cmd_o.t2         = t2_q;
    cmd_o.base0      = base_q;
  end

endmodule

/* hdl/dbmr_back.sv */
`timescale 1ns / 1ps
// back end: mask memory, clear sweep, box walk and word read
module dbmr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbmr_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           init_busy_o,
  input  logic [8:0]     cols_i,
  input  logic [15:0]    pixel_w_i,
  input  logic [15:0]    pixel_h_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    mask_word_o,
  output logic [1:0]     done_op_o
);
  import dbmr_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  back_state_e          state_q, state_d;
  logic                 init_q;
  logic [AW-1:0]        clr_q;
  cmd_t                 cmd_q;
  logic [8:0]           row_q, col_q;
  logic signed [35:0]   dx_q, dy_q;
  logic [17:0]          base_q;
  logic                 ay_ok_q, ax_ok_q;
  logic [49:0]          ay2_q, ax2_q;
  logic [AW-1:0]        addr_q;
  logic [BW-1:0]        bit_q;
  logic [WORD_BITS-1:0] word_q;
  logic                 out_valid_q;
  logic [31:0]          mask_word_q;
  op_e                  done_op_q;

  logic [35:0]          ay, ax;
  logic [17:0]          pix;
  logic [AW-1:0]        raddr, waddr;
  logic                 we, hit, last_col, last_row, empty_box, load;
  logic [WORD_BITS-1:0] wdata;

  assign ay        = dy_q[35] ? 36'(-dy_q) : 36'(dy_q);
  assign ax        = dx_q[35] ? 36'(-dx_q) : 36'(dx_q);
  assign pix       = base_q + {9'd0, col_q};
  assign hit       = ay_ok_q && ax_ok_q && ({1'b0, ax2_q} + {1'b0, ay2_q} <= {1'b0, cmd_q.t2});
  assign last_col  = ({1'b0, col_q} + 10'd1) == {1'b0, cmd_q.c1};
  assign last_row  = ({1'b0, row_q} + 10'd1) == {1'b0, cmd_q.r1};
  assign empty_box = (cmd_i.r0 >= cmd_i.r1) || (cmd_i.c0 >= cmd_i.c1);
  assign load      = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign init_busy_o = init_q;

  assign raddr = (state_q == B_SQ) ? pix[BW +: AW] : cmd_q.word_index[AW-1:0];
  assign we    = (state_q == B_CLR) || (state_q == B_WR && hit);
  assign waddr = (state_q == B_CLR) ? clr_q : addr_q;
  assign wdata = (state_q == B_CLR) ? '0 : (rdata_q | (WORD_BITS'(1) << bit_q));

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLR:  if (clr_q == AW'(DEPTH - 1)) state_d = init_q ? B_IDLE : B_DONE;
      B_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            OP_CLEAR: state_d = B_CLR;
            OP_BLOB:  state_d = empty_box ? B_DONE : B_ROW;
            OP_READ:  state_d = B_RD;
            default:  state_d = B_DONE;
          endcase
        end
      end
      B_RD:   state_d = B_RD2;
      B_RD2:  state_d = B_DONE;
      B_ROW:  state_d = B_SQ;
      B_SQ:   state_d = B_WR;
      B_WR:   if (!last_col) state_d = B_SQ;
              else state_d = last_row ? B_DONE : B_ROW;
      B_DONE: if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLR) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) init_q <= 1'b0;
      end
      if (state_q == B_DONE && load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cmd_q  <= cmd_i;
        word_q <= '0;
        row_q  <= cmd_i.r0;
        dy_q   <= cmd_i.dy0;
        base_q <= cmd_i.base0;
      end
      B_RD2: word_q <= rdata_q;
      B_ROW: begin
        ay_ok_q <= ay <= {11'd0, cmd_q.t};
        ay2_q   <= 50'(ay[24:0]) * 50'(ay[24:0]);
        col_q   <= cmd_q.c0;
        dx_q    <= cmd_q.dx0;
      end
      B_SQ: begin
        ax_ok_q <= ax <= {11'd0, cmd_q.t};
        ax2_q   <= 50'(ax[24:0]) * 50'(ax[24:0]);
        addr_q  <= pix[BW +: AW];
        bit_q   <= pix[BW-1:0];
      end
      B_WR: begin
        col_q <= col_q + 9'd1;
        dx_q  <= dx_q + $signed({20'd0, pixel_w_i});
        if (last_col) begin
          row_q  <= row_q + 9'd1;
          dy_q   <= dy_q - $signed({20'd0, pixel_h_i});
          base_q <= base_q + {9'd0, cols_i};
        end
      end
      B_DONE: begin
        if (load) begin
          mask_word_q <= word_q[31:0];
          done_op_q   <= cmd_q.op;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mask_word_o = mask_word_q;
  assign done_op_o   = done_op_q;

endmodule

/* hdl/disc_blob_mask_rasterizer.sv */
`timescale 1ns / 1ps
// Disc blob mask rasterizer: 256 x 256 one-bit mask in a 2048 x 32 memory.
// After reset the memory is swept to zero, during which time
// in_stall_o is high; configuration writes are taken at any time. A clear
// sweeps the memory one word per cycle. A blob passes through the front end
// (four serial 34-step divisions for the centre and box size) and then the
// back end, which spends a row step on each box row and a read and a write on
// each box pixel, so that each pixel is a read-modify-write of the mask
// memory through its separate read and write ports. Front and back are
// parted by a two-entry queue, so the next item's setup overlaps the walk.
module disc_blob_mask_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] blob_x_i,
  input  logic signed [31:0] blob_y_i,
  input  logic [23:0]        blob_r_i,
  input  logic [10:0]        word_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        mask_word_o,
  output logic [1:0]         done_op_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import dbmr_pkg::*;

  logic [8:0]         cols_q, rows_q;
  logic signed [31:0] origin_x_q, origin_y_q;
  logic [15:0]        pixel_w_q, pixel_h_q;
  logic [9:0]         margin_q;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty, init_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= 9'(MAX_COLS);
      rows_q     <= 9'(MAX_ROWS);
      origin_x_q <= '0;
      origin_y_q <= '0;
      pixel_w_q  <= 16'd256;
      pixel_h_q  <= 16'd256;
      margin_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_index_i))
        REG_COLS: begin
          if (cfg_data_i[8:0] == 9'd0) cols_q <= 9'd1;
          else if (cfg_data_i[8:0] > 9'(MAX_COLS)) cols_q <= 9'(MAX_COLS);
          else cols_q <= cfg_data_i[8:0];
        end
        REG_ROWS: begin
          if (cfg_data_i[8:0] == 9'd0) rows_q <= 9'd1;
          else if (cfg_data_i[8:0] > 9'(MAX_ROWS)) rows_q <= 9'(MAX_ROWS);
          else rows_q <= cfg_data_i[8:0];
        end
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        REG_PIXEL_W:  pixel_w_q <= (cfg_data_i[15:0] == 16'd0) ? 16'd1 : cfg_data_i[15:0];
        REG_PIXEL_H:  pixel_h_q <= (cfg_data_i[15:0] == 16'd0) ? 16'd1 : cfg_data_i[15:0];
        REG_MARGIN:   margin_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  dbmr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .hold_i       (init_busy),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .blob_x_i     (blob_x_i),
    .blob_y_i     (blob_y_i),
    .blob_r_i     (blob_r_i),
    .word_index_i (word_index_i),
    .cols_i       (cols_q),
    .rows_i       (rows_q),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .pixel_w_i    (pixel_w_q),
    .pixel_h_i    (pixel_h_q),
    .margin_i     (margin_q),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .full_i       (full)
  );

  dbmr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  dbmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .cols_i      (cols_q),
    .pixel_w_i   (pixel_w_q),
    .pixel_h_i   (pixel_h_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mask_word_o (mask_word_o),
    .done_op_o   (done_op_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue underflow");

  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> in_stall_o) else $error("item taken during memory sweep");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_op_o != OP_READ) |-> mask_word_o == 32'd0)
    else $error("nonzero word on non-read transfer");

endmodule

/* sim/tb_disc_blob_mask_rasterizer.sv */
`timescale 1ns / 1ps
// self-checking testbench of the disc blob mask rasterizer with its own mask predictor
module tb_disc_blob_mask_rasterizer;
  import dbmr_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  op;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_CLEAR;
  logic signed [31:0] blob_x_i = '0;
  logic signed [31:0] blob_y_i = '0;
  logic [23:0]        blob_r_i = '0;
  logic [10:0]        word_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        mask_word_o;
  logic [1:0]         done_op_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = REG_COLS;
  logic [31:0]        cfg_data_i = '0;

  disc_blob_mask_rasterizer u_top (.*);

  // predicted block state
  logic [31:0] mask_img [DEPTH];
  longint grid_cols, grid_rows, org_x, org_y, pix_w, pix_h, buf16;

  result_t pending_results[$];
  int      n_err = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  longint  cycle_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom % 100) < recv_stall_pct;
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: mask_word %h done_op %0d", mask_word_o, done_op_o);
        n_err++;
      end else begin
        exp_r = pending_results.pop_front();
        if (mask_word_o !== exp_r.word) begin
          $error("mask_word expected %h actual %h", exp_r.word, mask_word_o);
          n_err++;
        end
        if (done_op_o !== exp_r.op) begin
          $error("done_op expected %0d actual %0d", exp_r.op, done_op_o);
          n_err++;
        end
      end
    end
  end

  function automatic longint lclamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void reset_model();
    foreach (mask_img[i]) mask_img[i] = '0;
    grid_cols = 256;
    grid_rows = 256;
    org_x = 0;
    org_y = 0;
    pix_w = 256;
    pix_h = 256;
    buf16 = 0;
  endfunction

  function automatic void write_model_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_COLS:     grid_cols = lclamp(longint'(val[8:0]), 1, MAX_COLS);
      REG_ROWS:     grid_rows = lclamp(longint'(val[8:0]), 1, MAX_ROWS);
      REG_ORIGIN_X: org_x = longint'($signed(val));
      REG_ORIGIN_Y: org_y = longint'($signed(val));
      REG_PIXEL_W:  pix_w = lclamp(longint'(val[15:0]), 1, 65535);
      REG_PIXEL_H:  pix_h = lclamp(longint'(val[15:0]), 1, 65535);
      REG_MARGIN:   buf16 = longint'(val[9:0]);
      default: ;
    endcase
  endfunction

  // quotient rounded half away from zero
  function automatic longint round_div(longint n, longint d);
    longint m;
    longint q;
    m = n < 0 ? -n : n;
    q = (2 * m + d) / (2 * d);
    return n < 0 ? -q : q;
  endfunction

  // half-open pixel span of one axis, clamped to [0, lim]
  function automatic void box_span(longint c, longint r, longint pix, longint lim,
                                   output longint lo, output longint hi);
    longint half;
    longint lo16;
    longint hi16;
    half = (r + pix - 1) / pix + 1;
    lo16 = (c - half) * 16 - buf16;
    hi16 = (c + half) * 16 + buf16;
    lo = lo16 <= 0 ? 0 : lo16 >>> 4;
    hi = hi16 <= 0 ? 0 : hi16 >>> 4;
    if (lo > lim) lo = lim;
    if (hi > lim) hi = lim;
  endfunction

  function automatic void paint_disc(longint bx, longint by, longint r);
    longint ci, cj, c0, c1, r0, r1, t, t2, dx, dy, p;
    ci = round_div(bx - org_x, pix_w);
    cj = round_div(org_y - by, pix_h);
    t = r + (buf16 * (pix_w + pix_h)) / 32;
    t2 = t * t;
    box_span(ci, r, pix_w, grid_cols, c0, c1);
    box_span(cj, r, pix_h, grid_rows, r0, r1);
    for (longint row = r0; row < r1; row++) begin
      dy = org_y - row * pix_h - by;
      if (dy < 0) dy = -dy;
      if (dy > t) continue;
      for (longint col = c0; col < c1; col++) begin
        dx = org_x + col * pix_w - bx;
        if (dx < 0) dx = -dx;
        if (dx > t) continue;
        if (dx * dx + dy * dy > t2) continue;
        p = row * grid_cols + col;
        mask_img[(p / WORD_BITS) % DEPTH][p % WORD_BITS] = 1'b1;
      end
    end
  endfunction

  function automatic result_t predict_result(logic [1:0] op, logic signed [31:0] bx,
                                             logic signed [31:0] by, logic [23:0] r,
                                             logic [10:0] idx);
    result_t res;
    res.word = '0;
    res.op = op;
    case (op)
      OP_CLEAR: foreach (mask_img[i]) mask_img[i] = '0;
      OP_BLOB:  paint_disc(longint'(bx), longint'(by), longint'(r));
      OP_READ:  res.word = mask_img[idx % DEPTH];
      default: ;
    endcase
    return res;
  endfunction

  // one command transfer; called and returns just after a falling edge
  task automatic send_item(logic [1:0] op, logic signed [31:0] bx, logic signed [31:0] by,
                           logic [23:0] r, logic [10:0] idx);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    blob_x_i = bx;
    blob_y_i = by;
    blob_r_i = r;
    word_index_i = idx;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_results.push_back(predict_result(op, bx, by, r, idx));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    write_model_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic setup_grid(int c, int r, int ox, int oy, int pw, int ph, int m);
    drain_results();
    repeat (10) @(negedge clk_i);
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_PIXEL_W, pw);
    write_reg(REG_PIXEL_H, ph);
    write_reg(REG_MARGIN, m);
  endtask

  task automatic test_default_grid();
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_NONE, -1, -1, 24'hFFFFFF, 11'h7FF);
    send_item(OP_BLOB, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_BLOB, 255 * 256, -255 * 256, 512, 0);
    send_item(OP_READ, 0, 0, 0, 11'h7FF);
    send_item(OP_READ, 0, 0, 0, 11'h7F7);
    send_item(OP_BLOB, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
    send_item(OP_BLOB, 100 * 256 + 128, -(40 * 256 + 128), 700, 0);
    send_item(OP_READ, 0, 0, 0, (40 * 256 + 100) / 32);
    send_item(OP_READ, 0, 0, 0, (41 * 256 + 100) / 32);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    // zero sizes clamp up, oversize grid clamps down, the spare index is ignored
    setup_grid(0, 9'h1FF, 32'h80000000, 32'h7FFFFFFF, 0, 16'hFFFF, 1023);
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    send_item(OP_BLOB, 32'sh80000000, 32'sh7FFFFFFF, 24'hFFFFFF, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 7);
    send_item(OP_BLOB, 32'sh7FFFFFFF, 32'sh80000000, 24'hFFFFFF, 0);
    setup_grid(9'h1FF, 0, 0, 0, 16'hFFFF, 0, 0);
    send_item(OP_BLOB, 3 * 65535, 0, 65535, 0);
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 7);
  endtask

  task automatic random_items(int count, bit wide_radius, bit with_pause);
    int          k;
    logic [10:0] idx;
    logic [31:0] bx;
    logic [31:0] by;
    logic [23:0] r;
    longint      words;
    for (int n = 0; n < count; n++) begin
      if (with_pause && n == count / 2) drain_results();
      k = $urandom % 100;
      words = (grid_rows * grid_cols + WORD_BITS - 1) / WORD_BITS;
      if (k < 3) begin
        send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (k < 8) begin
        send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
      end else if (k < 52) begin
        if ($urandom % 10 == 0) begin
          bx = $urandom;
          by = $urandom;
        end else begin
          bx = org_x + $urandom_range(0, grid_cols - 1) * pix_w
               + $urandom_range(0, 2 * pix_w) - pix_w;
          by = org_y - $urandom_range(0, grid_rows - 1) * pix_h
               + $urandom_range(0, 2 * pix_h) - pix_h;
        end
        if (wide_radius && $urandom % 15 == 0) r = $urandom;
        else r = $urandom_range(0, 3 * (pix_w > pix_h ? pix_w : pix_h));
        send_item(OP_BLOB, bx, by, r, $urandom);
      end else begin
        if ($urandom % 10 < 3) idx = $urandom;
        else idx = $urandom_range(0, words - 1);
        send_item(OP_READ, $urandom, $urandom, $urandom, idx);
      end
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 27;
    recv_stall_pct = 79;
    setup_grid(256, 256, $urandom, $urandom, 256, 256, $urandom_range(0, 32));
    random_items(175, 1'b0, 1'b1);
    send_idle_pct = 79;
    recv_stall_pct = 27;
    setup_grid($urandom_range(1, 64), $urandom_range(1, 64), $urandom, $urandom,
               $urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(0, 48));
    random_items(175, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setup_grid(200, 37, -1000, 5000, 100, 300, 20);
    random_items(175, 1'b0, 1'b0);
  endtask

  initial begin
    reset_model();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_grid();
    test_register_extremes();
    test_random_phases();
    drain_results();
    repeat (50) @(negedge clk_i);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* disc_blob_mask_rasterizer.f */
hdl/dbmr_pkg.sv
hdl/dbmr_fifo.sv
hdl/dbmr_front.sv
hdl/dbmr_back.sv
hdl/disc_blob_mask_rasterizer.sv
sim/tb_disc_blob_mask_rasterizer.sv
